/* rtl/ss_pkg.sv */
// Shared types and constants for the substring search block.
`timescale 1ns / 1ps

package ss_pkg;

   localparam int MAX_NEEDLE_DEFAULT   = 16;
   localparam int MAX_HAYSTACK_DEFAULT = 65536;
   localparam int POS_W                = 16;

   typedef enum logic [1:0] {
      KIND_START    = 2'd0,
      KIND_NEEDLE   = 2'd1,
      KIND_HAYSTACK = 2'd2,
      KIND_END      = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  character;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [POS_W-1:0]  position;
      logic              needle_overflow;
      logic              haystack_overflow;
   } rsp_type;

endpackage

/* rtl/substring_search.sv */
// Top level of the substring search block: stream matcher with a parallel window compare.
//
// Usage: every word on the req channel carries a kind and a character. A start word opens
// a new search, needle words append to the needle, haystack words shift into the window,
// and an end word makes the block send one rsp word with the found flag, the start
// position of the first match and the two overflow flags. Only end words give a result.
// Both channels use valid and ready; a word moves when both are high.
// A request word is held in an input register and is applied to the search state from
// there; an end word's result is registered in the output register and shown on rsp.
// One word is taken every cycle while req_ready is high: the needle is kept in a shift
// register aligned with the haystack window, so each haystack byte is checked by one
// row of byte comparators. When the receiver stalls, the result stays in the output
// register; needle and haystack words keep flowing, and only an end word waits in the
// input register, which then lowers req_ready until the output register is free.
// Reset empties the needle and the window and leaves an open, empty search, as a start
// word does. No clearing pass is needed.

`timescale 1ns / 1ps

module substring_search #(
   parameter int MAX_NEEDLE   = ss_pkg::MAX_NEEDLE_DEFAULT,
   parameter int MAX_HAYSTACK = ss_pkg::MAX_HAYSTACK_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ss_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ss_pkg::rsp_type rsp_data
);

   localparam int NEED_W = $clog2(MAX_NEEDLE + 1);
   localparam int SEEN_W = $clog2(MAX_HAYSTACK + 1);
   localparam int CMP_W  = (NEED_W > SEEN_W) ? NEED_W : SEEN_W;

   logic                     in_valid_ff, in_valid_in;
   ss_pkg::req_type          in_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   ss_pkg::rsp_type          rsp_ff, rsp_in;

   logic [7:0]               ndl_ff [MAX_NEEDLE];
   logic [7:0]               ndl_in [MAX_NEEDLE];
   logic [7:0]               win_ff [MAX_NEEDLE];
   logic [7:0]               win_in [MAX_NEEDLE];
   logic [NEED_W-1:0]        count_ff, count_in;
   logic                     ndl_drop_ff, ndl_drop_in;
   logic [SEEN_W-1:0]        seen_ff, seen_in;
   logic                     hay_drop_ff, hay_drop_in;
   logic                     match_ff, match_in;
   logic [ss_pkg::POS_W-1:0] start_ff, start_in;

   logic                     stall;
   logic                     proceed;
   logic [MAX_NEEDLE-1:0]    byte_ok;
   logic                     window_hit;
   logic [SEEN_W-1:0]        seen_next;
   logic [SEEN_W-1:0]        start_diff;

   assign stall     = in_valid_ff && (in_ff.kind == ss_pkg::KIND_END) &&
                      rsp_valid_ff && !rsp_ready;
   assign req_ready = !stall;
   assign proceed   = in_valid_ff && !stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign seen_next  = seen_ff + SEEN_W'(1);
   assign start_diff = seen_next - SEEN_W'(count_ff);

   // Entry a of the needle register holds the needle byte that must sit at age a.
   always_comb begin
      byte_ok[0] = (count_ff == '0) || (in_ff.character == ndl_ff[0]);
      for (int a = 1; a < MAX_NEEDLE; a++) begin
         if (NEED_W'(a) < count_ff) begin
            byte_ok[a] = (win_ff[a-1] == ndl_ff[a]);
         end else begin
            byte_ok[a] = 1'b1;
         end
      end
      window_hit = &byte_ok;
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ndl_in       = ndl_ff;
      win_in       = win_ff;
      count_in     = count_ff;
      ndl_drop_in  = ndl_drop_ff;
      seen_in      = seen_ff;
      hay_drop_in  = hay_drop_ff;
      match_in     = match_ff;
      start_in     = start_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_ready) begin
         in_valid_in = req_valid;
      end

      if (proceed) begin
         case (in_ff.kind)
            ss_pkg::KIND_START: begin
               count_in    = '0;
               ndl_drop_in = 1'b0;
               seen_in     = '0;
               hay_drop_in = 1'b0;
               match_in    = 1'b0;
               start_in    = '0;
            end
            ss_pkg::KIND_NEEDLE: begin
               if (count_ff == NEED_W'(MAX_NEEDLE)) begin
                  ndl_drop_in = 1'b1;
               end else begin
                  ndl_in[0] = in_ff.character;
                  for (int a = 1; a < MAX_NEEDLE; a++) begin
                     ndl_in[a] = ndl_ff[a-1];
                  end
                  count_in = count_ff + NEED_W'(1);
               end
            end
            ss_pkg::KIND_HAYSTACK: begin
               if (seen_ff == SEEN_W'(MAX_HAYSTACK)) begin
                  hay_drop_in = 1'b1;
               end else begin
                  win_in[0] = in_ff.character;
                  for (int a = 1; a < MAX_NEEDLE; a++) begin
                     win_in[a] = win_ff[a-1];
                  end
                  seen_in = seen_next;
                  if (!match_ff && (count_ff != '0) &&
                      (CMP_W'(seen_next) >= CMP_W'(count_ff)) && window_hit) begin
                     match_in = 1'b1;
                     start_in = ss_pkg::POS_W'(start_diff);
                  end
               end
            end
            ss_pkg::KIND_END: begin
               rsp_valid_in              = 1'b1;
               rsp_in.found              = (count_ff == '0) || match_ff;
               rsp_in.position           = ((count_ff != '0) && match_ff) ? start_ff : '0;
               rsp_in.needle_overflow    = ndl_drop_ff;
               rsp_in.haystack_overflow  = hay_drop_ff;
            end
            default: begin
               rsp_valid_in = rsp_valid_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         ndl_drop_ff  <= 1'b0;
         seen_ff      <= '0;
         hay_drop_ff  <= 1'b0;
         match_ff     <= 1'b0;
         start_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         ndl_drop_ff  <= ndl_drop_in;
         seen_ff      <= seen_in;
         hay_drop_ff  <= hay_drop_in;
         match_ff     <= match_in;
         start_ff     <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      rsp_ff <= rsp_in;
      ndl_ff <= ndl_in;
      win_ff <= win_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NEED_W'(MAX_NEEDLE))
      else $error("needle count exceeds capacity");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_W'(MAX_HAYSTACK))
      else $error("haystack count exceeds capacity");

   a_match_needs_needle: assert property (@(posedge clock) disable iff (reset)
      match_ff |-> (count_ff != '0))
      else $error("match recorded with an empty needle");

   a_end_waits: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && (in_ff.kind == ss_pkg::KIND_END) && rsp_valid_ff && !rsp_ready)
      |=> (in_valid_ff && (in_ff.kind == ss_pkg::KIND_END) && rsp_valid_ff))
      else $error("end word lost while the output was stalled");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the substring search block.
`timescale 1ns / 1ps

module testbench;

   localparam int NEEDLE_CAP = ss_pkg::MAX_NEEDLE_DEFAULT;
   localparam int TEXT_CAP   = ss_pkg::MAX_HAYSTACK_DEFAULT;
   localparam int STALL_LIMIT = 2000;

   localparam ss_pkg::rsp_type EMPTY_HIT = {1'b1, 16'h0000, 1'b0, 1'b0};
   localparam ss_pkg::rsp_type NO_HIT    = '0;

   typedef struct packed {
      ss_pkg::kind_type kind;
      logic [7:0]       character;
      logic             typed;
      ss_pkg::rsp_type  want;
   } plan_row_type;

   localparam int PLAN_ROWS = 19;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{ss_pkg::KIND_END,      8'h00, 1'b1, EMPTY_HIT},
      '{ss_pkg::KIND_START,    8'hFF, 1'b0, NO_HIT},
      '{ss_pkg::KIND_END,      8'h00, 1'b1, EMPTY_HIT},
      '{ss_pkg::KIND_NEEDLE,   8'hFF, 1'b0, NO_HIT},
      '{ss_pkg::KIND_NEEDLE,   8'h00, 1'b0, NO_HIT},
      '{ss_pkg::KIND_HAYSTACK, 8'h00, 1'b0, NO_HIT},
      '{ss_pkg::KIND_END,      8'h00, 1'b1, NO_HIT},
      '{ss_pkg::KIND_HAYSTACK, 8'hFF, 1'b0, NO_HIT},
      '{ss_pkg::KIND_HAYSTACK, 8'h00, 1'b0, NO_HIT},
      '{ss_pkg::KIND_END,      8'h00, 1'b0, NO_HIT},
      '{ss_pkg::KIND_NEEDLE,   8'hAA, 1'b0, NO_HIT},
      '{ss_pkg::KIND_END,      8'h00, 1'b0, NO_HIT},
      '{ss_pkg::KIND_HAYSTACK, 8'hAA, 1'b0, NO_HIT},
      '{ss_pkg::KIND_END,      8'h00, 1'b0, NO_HIT},
      '{ss_pkg::KIND_START,    8'hA5, 1'b0, NO_HIT},
      '{ss_pkg::KIND_NEEDLE,   8'h5A, 1'b0, NO_HIT},
      '{ss_pkg::KIND_END,      8'hFF, 1'b1, NO_HIT},
      '{ss_pkg::KIND_HAYSTACK, 8'h5A, 1'b0, NO_HIT},
      '{ss_pkg::KIND_END,      8'h00, 1'b0, NO_HIT}
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   ss_pkg::req_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   ss_pkg::rsp_type rsp_data;

   logic            use_typed = 1'b0;
   ss_pkg::rsp_type typed_result = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int words_sent = 0;
   int ends_sent = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   ss_pkg::rsp_type pending_results [$];

   // Predictor copy of the search state.
   logic [7:0]  pattern [NEEDLE_CAP];
   logic [4:0]  pattern_len;
   logic        pattern_dropped;
   logic [7:0]  recent_text [NEEDLE_CAP];
   logic [16:0] text_len;
   logic        text_dropped;
   logic        hit;
   logic [15:0] hit_start;

   substring_search u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic clear_search();
      for (int i = 0; i < NEEDLE_CAP; i++) begin
         pattern[i] = '0;
         recent_text[i] = '0;
      end
      pattern_len = '0;
      pattern_dropped = 1'b0;
      text_len = '0;
      text_dropped = 1'b0;
      hit = 1'b0;
      hit_start = '0;
   endtask

   task automatic search_step(input ss_pkg::req_type w, output logic produced,
                              output ss_pkg::rsp_type r);
      logic same;
      produced = 1'b0;
      r = '0;
      case (w.kind)
         ss_pkg::KIND_START: begin
            clear_search();
         end
         ss_pkg::KIND_NEEDLE: begin
            if (pattern_len < NEEDLE_CAP) begin
               pattern[pattern_len] = w.character;
               pattern_len = pattern_len + 1'b1;
            end else begin
               pattern_dropped = 1'b1;
            end
         end
         ss_pkg::KIND_HAYSTACK: begin
            if (text_len >= TEXT_CAP) begin
               text_dropped = 1'b1;
            end else begin
               for (int k = NEEDLE_CAP - 1; k > 0; k--) recent_text[k] = recent_text[k - 1];
               recent_text[0] = w.character;
               text_len = text_len + 1'b1;
               if (!hit && pattern_len != 0 && text_len >= pattern_len) begin
                  same = 1'b1;
                  for (int j = 0; j < pattern_len; j++) begin
                     if (recent_text[pattern_len - 1 - j] != pattern[j]) same = 1'b0;
                  end
                  if (same) begin
                     hit = 1'b1;
                     hit_start = 16'(text_len - pattern_len);
                  end
               end
            end
         end
         default: begin
            produced = 1'b1;
            r.found = (pattern_len == 0) || hit;
            r.position = (pattern_len != 0 && hit) ? hit_start : 16'h0000;
            r.needle_overflow = pattern_dropped;
            r.haystack_overflow = text_dropped;
         end
      endcase
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      logic            produced;
      ss_pkg::rsp_type predicted;
      ss_pkg::rsp_type oldest;
      if (reset) begin
         clear_search();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result word, expected none actual %h",
                        $time, rsp_data);
               mismatches++;
            end else begin
               oldest = pending_results.pop_front();
               check_field("found", oldest.found, rsp_data.found);
               check_field("position", oldest.position, rsp_data.position);
               check_field("needle_overflow", oldest.needle_overflow, rsp_data.needle_overflow);
               check_field("haystack_overflow", oldest.haystack_overflow,
                           rsp_data.haystack_overflow);
            end
         end
         if (req_valid && req_ready) begin
            search_step(req_data, produced, predicted);
            if (produced) pending_results.push_back(use_typed ? typed_result : predicted);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved in %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_word(input ss_pkg::req_type w, input logic typed,
                            input ss_pkg::rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      use_typed <= typed;
      typed_result <= want;
      words_sent++;
      if (w.kind == ss_pkg::KIND_END) ends_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_item(input ss_pkg::kind_type kind, input logic [7:0] ch);
      ss_pkg::req_type w;
      w.kind = kind;
      w.character = ch;
      send_word(w, 1'b0, NO_HIT);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [7:0] pick_char(input logic [7:0] a, input logic [7:0] b,
                                            input bit wide);
      if (wide) return 8'($urandom_range(255));
      return $urandom_range(1) ? a : b;
   endfunction

   task automatic random_search();
      logic [7:0] pat [$];
      logic [7:0] hay [$];
      logic [7:0] a;
      logic [7:0] b;
      bit wide;
      int plen;
      int hlen;
      int at;
      int extra_at;
      a = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
      wide = ($urandom_range(3) == 0);
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 10))
            send_item(ss_pkg::kind_type'($urandom_range(3)), 8'($urandom_range(255)));
         send_item(ss_pkg::KIND_END, 8'($urandom_range(255)));
         return;
      end
      case ($urandom_range(9))
         0: plen = 0;
         1: plen = $urandom_range(5, 18);
         default: plen = $urandom_range(1, 4);
      endcase
      hlen = $urandom_range(0, 40);
      repeat (plen) pat.push_back(pick_char(a, b, wide));
      repeat (hlen) hay.push_back(pick_char(a, b, wide));
      if (plen > 0 && plen <= NEEDLE_CAP && plen <= hlen && $urandom_range(99) < 60) begin
         at = $urandom_range(0, hlen - plen);
         for (int j = 0; j < plen; j++) hay[at + j] = pat[j];
      end
      extra_at = ($urandom_range(9) == 0) ? $urandom_range(0, hlen) : -1;
      send_item(ss_pkg::KIND_START, 8'($urandom_range(255)));
      foreach (pat[i]) send_item(ss_pkg::KIND_NEEDLE, pat[i]);
      for (int i = 0; i < hlen; i++) begin
         if (i == extra_at) send_item(ss_pkg::KIND_NEEDLE, pick_char(a, b, wide));
         send_item(ss_pkg::KIND_HAYSTACK, hay[i]);
      end
      send_item(ss_pkg::KIND_END, 8'($urandom_range(255)));
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(0, 5)) send_item(ss_pkg::KIND_HAYSTACK, pick_char(a, b, wide));
         send_item(ss_pkg::KIND_END, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      logic [7:0] full_pattern [NEEDLE_CAP];
      ss_pkg::req_type w;
      int first_word;
      int first_end;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         if (ph == 0) begin
            for (int r = 0; r < PLAN_ROWS; r++) begin
               w.kind = PLAN[r].kind;
               w.character = PLAN[r].character;
               send_word(w, PLAN[r].typed, PLAN[r].want);
            end

            // An over-long needle whose first sixteen bytes sit inside the haystack.
            send_item(ss_pkg::KIND_START, 8'h00);
            for (int i = 0; i < NEEDLE_CAP; i++) begin
               full_pattern[i] = 8'($urandom_range(255));
               send_item(ss_pkg::KIND_NEEDLE, full_pattern[i]);
            end
            repeat (2) send_item(ss_pkg::KIND_NEEDLE, 8'($urandom_range(255)));
            repeat (5) send_item(ss_pkg::KIND_HAYSTACK, 8'($urandom_range(255)));
            for (int i = 0; i < NEEDLE_CAP; i++)
               send_item(ss_pkg::KIND_HAYSTACK, full_pattern[i]);
            repeat (3) send_item(ss_pkg::KIND_HAYSTACK, 8'($urandom_range(255)));
            send_item(ss_pkg::KIND_END, 8'h00);
            wait_drained();
         end
         first_word = words_sent;
         first_end = ends_sent;
         while (words_sent - first_word < 160 || ends_sent - first_end < 15) random_search();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
